// ===== sv/vdes_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdes_pkg
// Types, constants and saturating helpers for the viral dynamics Euler step.
// ----------------------------------------------------------------------------
package vdes_pkg;

    localparam int W     = 48;
    localparam int RATE_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [W-1:0] S48_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] S48_MIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INFECTION  = 3'd0,
        CFG_ECLIPSE    = 3'd1,
        CFG_DEATH      = 3'd2,
        CFG_PRODUCTION = 3'd3,
        CFG_CLEARANCE  = 3'd4,
        CFG_TIME_STEP  = 3'd5,
        CFG_SICK       = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic                action;
        logic signed [W-1:0] exposure;
        logic signed [W-1:0] load_target;
        logic signed [W-1:0] load_eclipse;
        logic signed [W-1:0] load_infected;
        logic signed [W-1:0] load_virus;
    } in_word_t;

    typedef struct packed {
        logic signed [W-1:0] target_cells;
        logic signed [W-1:0] eclipse_cells;
        logic signed [W-1:0] infected_cells;
        logic signed [W-1:0] virus_level;
        logic signed [W-1:0] peak_infected;
        logic                overflow;
    } out_word_t;

    typedef struct packed {
        logic                ov;
        logic signed [W-1:0] v;
    } sat_t;

    function automatic sat_t sat_fix(logic signed [W:0] s);
        sat_t r;
        r.ov = (s[W] != s[W-1]);
        r.v  = r.ov ? (s[W] ? S48_MIN : S48_MAX) : s[W-1:0];
        return r;
    endfunction

    function automatic sat_t sat_add(logic signed [W-1:0] a, logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        return sat_fix(s);
    endfunction

    function automatic sat_t sat_sub(logic signed [W-1:0] a, logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        return sat_fix(s);
    endfunction

endpackage
`default_nettype wire

// ===== sv/viral_dynamics_euler_step_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// viral_dynamics_euler_step_top
// Load or forward-Euler tick of a target / eclipse / infected / virus model.
// ----------------------------------------------------------------------------
// A load word copies its state into the registers and passes through the done
// state to post its result. A tick word computes ten products in turn, each
// in the steps operand setup, 48-bit bit-serial shift-add multiplication,
// rounding and saturation, accumulate, and then posts its result from the
// done state. The single shared bit-serial multiplier serializes the products.
// One word is in work at a time; the result register lets the next word be
// accepted while the previous result waits to be taken. A finished word whose
// result register is still held by out_stall waits in the done state until
// the register frees.
module viral_dynamics_euler_step_top
    import vdes_pkg::*;
#(
    parameter int FRACTION_BITS = 24
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [RATE_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_word_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_word_t                 out_data
);

    localparam int MUL_BITS = W;
    localparam int CNT_W = $clog2(MUL_BITS);
    localparam logic signed [W-1:0] FX_ONE = W'(longint'(1) << FRACTION_BITS);
    localparam logic signed [W-1:0] FX_V_FLOOR =
        W'(((longint'(1) << FRACTION_BITS) + 50) / 100);
    localparam logic signed [W-1:0] FX_I_FLOOR =
        W'(((longint'(1) << FRACTION_BITS) + 10) / 20);
    localparam logic [W:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};
    localparam logic [W:0] LIM_POS = {2'b00, {(W-1){1'b1}}};

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_MUL   = 6'b000100,
        S_RES   = 6'b001000,
        S_APPLY = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        OP_BT   = 4'd0,
        OP_BTV  = 4'd1,
        OP_KE   = 4'd2,
        OP_DI   = 4'd3,
        OP_PI   = 4'd4,
        OP_CV   = 4'd5,
        OP_DT_T = 4'd6,
        OP_DT_E = 4'd7,
        OP_DT_I = 4'd8,
        OP_DT_V = 4'd9
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [RATE_W-1:0] beta_reg, beta_next, k_reg, k_next, d_reg, d_next;
    logic [RATE_W-1:0] p_reg, p_next, c_reg, c_next, dt_reg, dt_next;
    logic sick_reg, sick_next;

    logic signed [W-1:0] t_reg, t_next, e_reg, e_next, i_reg, i_next;
    logic signed [W-1:0] v_reg, v_next, peak_reg, peak_next;
    logic ovf_reg, ovf_next;

    logic signed [W-1:0] xc_reg, xc_next, btv_reg, btv_next, ke_reg, ke_next;
    logic signed [W-1:0] di_reg, di_next, dv_reg, dv_next, mres_reg, mres_next;

    logic [W-1:0] ma_reg, ma_next, mb_reg, mb_next, hi_reg, hi_next, lo_reg, lo_next;
    logic neg_reg, neg_next;

    logic out_valid_reg, out_valid_next;
    out_word_t out_data_reg, out_data_next;

    logic signed [W-1:0] opa, opb;
    logic                pre_ov;
    sat_t                s_neg, s_sub, s1, s2;
    logic [W:0]          psum;
    logic [2*W-1:0]      prod;
    logic [W-1:0]        q;
    logic [W:0]          qa;
    logic                hi_ov, r_nz, m_ov;
    logic signed [W-1:0] vn, inew;
    logic                accept, out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign s_neg = sat_sub('0, btv_reg);
    assign s_sub = sat_sub(btv_reg, ke_reg);

    // operand select for the product about to start
    always_comb
    begin
        opa    = {{(W-RATE_W){1'b0}}, dt_reg};
        opb    = di_reg;
        pre_ov = 1'b0;
        case (op_reg)
            OP_BT:   begin opa = {{(W-RATE_W){1'b0}}, beta_reg}; opb = t_reg; end
            OP_BTV:  begin opa = btv_reg; opb = v_reg; end
            OP_KE:   begin opa = {{(W-RATE_W){1'b0}}, k_reg}; opb = e_reg; end
            OP_DI:   begin opa = {{(W-RATE_W){1'b0}}, d_reg}; opb = i_reg; end
            OP_PI:   begin opa = {{(W-RATE_W){1'b0}}, p_reg}; opb = i_reg; end
            OP_CV:   begin opa = {{(W-RATE_W){1'b0}}, c_reg}; opb = v_reg; end
            OP_DT_T: begin opb = s_neg.v; pre_ov = s_neg.ov; end
            OP_DT_E: begin opb = s_sub.v; pre_ov = s_sub.ov; end
            OP_DT_I: opb = di_reg;
            OP_DT_V: opb = dv_reg;
            default: opb = di_reg;
        endcase
    end

    assign psum  = {1'b0, hi_reg} + (mb_reg[0] ? {1'b0, ma_reg} : '0);
    assign prod  = {hi_reg, lo_reg};
    assign q     = prod[FRACTION_BITS +: W];
    assign hi_ov = (prod >> (FRACTION_BITS + W)) != '0;
    assign r_nz  = (prod[FRACTION_BITS-1:0] != '0);
    assign qa    = {1'b0, q} + (W+1)'(neg_reg && r_nz);
    assign m_ov  = hi_ov || (qa > (neg_reg ? LIM_NEG : LIM_POS));

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        beta_next  = beta_reg;
        k_next     = k_reg;
        d_next     = d_reg;
        p_next     = p_reg;
        c_next     = c_reg;
        dt_next    = dt_reg;
        sick_next  = sick_reg;
        t_next     = t_reg;
        e_next     = e_reg;
        i_next     = i_reg;
        v_next     = v_reg;
        peak_next  = peak_reg;
        ovf_next   = ovf_reg;
        xc_next    = xc_reg;
        btv_next   = btv_reg;
        ke_next    = ke_reg;
        di_next    = di_reg;
        dv_next    = dv_reg;
        mres_next  = mres_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        neg_next   = neg_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        s1   = '0;
        s2   = '0;
        vn   = v_reg;
        inew = i_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_INFECTION:  beta_next = cfg_data;
                CFG_ECLIPSE:    k_next    = cfg_data;
                CFG_DEATH:      d_next    = cfg_data;
                CFG_PRODUCTION: p_next    = cfg_data;
                CFG_CLEARANCE:  c_next    = cfg_data;
                CFG_TIME_STEP:  dt_next   = cfg_data;
                CFG_SICK:       sick_next = cfg_data[0];
                default:        ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!in_data.action)
                    begin
                        t_next     = in_data.load_target;
                        e_next     = in_data.load_eclipse;
                        i_next     = in_data.load_infected;
                        v_next     = in_data.load_virus;
                        peak_next  = in_data.load_infected;
                        ovf_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        xc_next    = (in_data.exposure > FX_ONE) ? FX_ONE : in_data.exposure;
                        op_next    = OP_BT;
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                ma_next    = opa[W-1] ? W'(-opa) : opa;
                mb_next    = opb[W-1] ? W'(-opb) : opb;
                neg_next   = opa[W-1] ^ opb[W-1];
                hi_next    = '0;
                lo_next    = '0;
                cnt_next   = '0;
                ovf_next   = ovf_reg | pre_ov;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // add partial, shift one bit into the low half
                hi_next  = psum[W:1];
                lo_next  = {psum[0], lo_reg[W-1:1]};
                mb_next  = mb_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_BITS - 1))
                    state_next = S_RES;
            end
            S_RES:
            begin
                if (m_ov)
                    mres_next = neg_reg ? S48_MIN : S48_MAX;
                else
                    mres_next = neg_reg ? W'(-qa) : qa[W-1:0];
                ovf_next   = ovf_reg | m_ov;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = S_START;
                op_next    = op_t'(op_reg + 1'b1);
                case (op_reg)
                    OP_BT, OP_BTV: btv_next = mres_reg;
                    OP_KE:         ke_next  = mres_reg;
                    OP_DI:
                    begin
                        s1      = sat_sub(ke_reg, mres_reg);
                        di_next = s1.v;
                    end
                    OP_PI:         dv_next  = mres_reg;
                    OP_CV:
                    begin
                        s1      = sat_sub(dv_reg, mres_reg);
                        s2      = sat_add(s1.v, xc_reg);
                        dv_next = s2.v;
                    end
                    OP_DT_T:
                    begin
                        s1     = sat_add(t_reg, mres_reg);
                        t_next = s1.v;
                    end
                    OP_DT_E:
                    begin
                        s1     = sat_add(e_reg, mres_reg);
                        e_next = s1.v;
                    end
                    OP_DT_I:
                    begin
                        s1     = sat_add(i_reg, mres_reg);
                        i_next = s1.v;
                    end
                    OP_DT_V:
                    begin
                        s1 = sat_add(v_reg, mres_reg);
                        vn = (s1.v < FX_V_FLOOR) ? '0 : s1.v;
                        if (sick_reg && (i_reg < FX_I_FLOOR))
                        begin
                            vn   = '0;
                            inew = '0;
                        end
                        v_next     = vn;
                        i_next     = inew;
                        if (inew > peak_reg)
                            peak_next = inew;
                        state_next = S_DONE;
                    end
                    default: ;
                endcase
                ovf_next = ovf_reg | s1.ov | s2.ov;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_data_next.target_cells   = t_reg;
                    out_data_next.eclipse_cells  = e_reg;
                    out_data_next.infected_cells = i_reg;
                    out_data_next.virus_level    = v_reg;
                    out_data_next.peak_infected  = peak_reg;
                    out_data_next.overflow       = ovf_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_BT;
            cnt_reg       <= '0;
            beta_reg      <= '0;
            k_reg         <= '0;
            d_reg         <= '0;
            p_reg         <= '0;
            c_reg         <= '0;
            dt_reg        <= RATE_W'(167772);
            sick_reg      <= 1'b0;
            t_reg         <= '0;
            e_reg         <= '0;
            i_reg         <= '0;
            v_reg         <= '0;
            peak_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            beta_reg      <= beta_next;
            k_reg         <= k_next;
            d_reg         <= d_next;
            p_reg         <= p_next;
            c_reg         <= c_next;
            dt_reg        <= dt_next;
            sick_reg      <= sick_next;
            t_reg         <= t_next;
            e_reg         <= e_next;
            i_reg         <= i_next;
            v_reg         <= v_next;
            peak_reg      <= peak_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xc_reg       <= xc_next;
        btv_reg      <= btv_next;
        ke_reg       <= ke_next;
        di_reg       <= di_next;
        dv_reg       <= dv_next;
        mres_reg     <= mres_next;
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result posted outside the done state");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (cnt_reg < CNT_W'(MUL_BITS)))
        else $error("multiplier bit count out of range");

    a_load_clears_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_data.action) |=> (!ovf_reg && state_reg == S_DONE))
        else $error("load did not clear overflow");

    a_tick_enters_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.action) |=> (state_reg == S_START && op_reg == OP_BT))
        else $error("tick did not start at the first product");

endmodule
`default_nettype wire
